>>> hw/rtl/pin_pkg.sv
`default_nettype none
package pin_pkg;

  // Posterize levels and full scale of an unsigned byte.
  localparam int unsigned LEVELS     = 10;
  localparam int unsigned LEVEL_STEP = 25;
  localparam int unsigned FULL_SCALE = 255;

  // Widths of the serial divider: quotient is one byte, dividend 255 * byte.
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned QUOT_W     = 8;
  localparam int unsigned DIVIDEND_W = 16;

  // Status the divider reports back to the sequencer.
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } pin_div_status_t;

  // Posterize a red value into ten levels, the last matching level winning,
  // and invert it. Values at or above the top level are inverted without posterizing.
  function automatic logic [PIX_W-1:0] inverted_level(input logic [PIX_W-1:0] r);
    logic [PIX_W-1:0] lvl;
    lvl = PIX_W'(LEVEL_STEP);
    for (int k = 1; k < LEVELS; k++) begin
      if (r >= PIX_W'(LEVEL_STEP * k)) begin
        lvl = PIX_W'(LEVEL_STEP * (k + 1));
      end
    end
    if (r >= PIX_W'(LEVEL_STEP * LEVELS)) begin
      lvl = r;
    end
    return PIX_W'(FULL_SCALE) - lvl;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pin_divider.sv
`default_nettype none
module pin_divider (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [pin_pkg::DIVIDEND_W-1:0]  dividend,
  input  wire logic [pin_pkg::PIX_W-1:0]       divisor,
  output pin_pkg::pin_div_status_t             status
);
  import pin_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

  logic              running;
  logic              done;
  logic [CNT_W-1:0]  count;
  logic [PIX_W-1:0]  rem;
  logic [QUOT_W-1:0] shreg;
  logic [PIX_W-1:0]  dvs;

  logic [PIX_W:0]    trial;
  logic [PIX_W:0]    diff;
  logic              ge;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem, shreg[QUOT_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  // The upper dividend byte is already below the divisor, since the
  // quotient fits one byte, so only the lower byte is shifted through.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      count   <= CNT_W'(QUOT_W);
      rem     <= dividend[DIVIDEND_W-1 -: PIX_W];
      shreg   <= dividend[QUOT_W-1:0];
      dvs     <= divisor;
    end else if (running) begin
      rem   <= ge ? diff[PIX_W-1:0] : trial[PIX_W-1:0];
      shreg <= {shreg[QUOT_W-2:0], ge};
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  assign status.done     = done;
  assign status.quotient = shreg;

endmodule
`default_nettype wire

>>> hw/rtl/posterize_invert_normalize_unit.sv
`default_nettype none
// Posterize, invert and contrast-normalize the red channel of pixels.
// Input channel (in_valid / in_stall) carries one word per pixel: kind,
// red_value and frame_start. A measure word (kind 0) updates the running
// maximum of the inverted level and gives no result; frame_start clears the
// maximum first. An output word (kind 1) gives one result word on the output
// channel (out_valid / out_stall): gray_out = floor(255*(max-v)/max), or 255
// with zero_max set when the maximum is zero, or 0 when v exceeds it.
// Measure words are taken one per cycle while the sequencer is idle. An
// output word that needs the divide runs through a bit-serial restoring
// divider, one quotient bit per cycle; its result enters the output
// register once the divide is done and the register is free, and the next
// word is accepted at that same edge. Zero-maximum and saturated words
// wait in S_HOLD and enter the output register once it is free.
// The output register parts the two sides: a new word may be taken while a
// result waits there, but a second result holds the input stalled until the
// receiver drops out_stall. Reset clears the maximum, the sequencer and
// out_valid.
module posterize_invert_normalize_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      kind,
  input  wire logic [pin_pkg::PIX_W-1:0] red_value,
  input  wire logic                      frame_start,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [pin_pkg::PIX_W-1:0]      gray_out,
  output logic                           zero_max
);
  import pin_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_t;

  state_t                  state;
  logic [PIX_W-1:0]        inverted_max;
  logic [PIX_W-1:0]        pend_gray;
  logic                    pend_zero;

  logic [PIX_W-1:0]        v;
  logic [PIX_W-1:0]        diff;
  logic [PIX_W-1:0]        max_base;
  logic [DIVIDEND_W-1:0]   dividend;
  logic                    res_ready;
  logic [PIX_W-1:0]        res_gray;
  logic                    res_zero;
  logic                    out_free;
  logic                    take;
  logic                    accept;
  logic                    fast_zero;
  logic                    fast_sat;
  logic                    div_start;
  pin_div_status_t         div_status;

  // Inverted level of the incoming word and the scaled difference 255*(max-v).
  always_comb begin
    v        = inverted_level(red_value);
    diff     = inverted_max - v;
    dividend = {diff, {PIX_W{1'b0}}} - {{(DIVIDEND_W-PIX_W){1'b0}}, diff};
    max_base = frame_start ? '0 : inverted_max;
  end

  // A result is ready from the fast path or from a finished divide.
  always_comb begin
    res_ready = (state == S_HOLD) || ((state == S_DIV) && div_status.done);
    res_gray  = (state == S_HOLD) ? pend_gray : div_status.quotient;
    res_zero  = (state == S_HOLD) ? pend_zero : 1'b0;
    out_free  = !out_valid || !out_stall;
    take      = res_ready && out_free;
    in_stall  = !((state == S_IDLE) || take);
    accept    = in_valid && !in_stall;
    fast_zero = (inverted_max == '0);
    fast_sat  = (v > inverted_max);
    div_start = accept && kind && !fast_zero && !fast_sat;
  end

  pin_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (inverted_max),
    .status   (div_status)
  );

  // Sequencer, running maximum and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      inverted_max <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        gray_out  <= res_gray;
        zero_max  <= res_zero;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // A word taken in the same cycle as a result decides the next state.
      if (accept) begin
        if (!kind) begin
          inverted_max <= (v > max_base) ? v : max_base;
          state        <= S_IDLE;
        end else if (fast_zero) begin
          pend_gray <= PIX_W'(FULL_SCALE);
          pend_zero <= 1'b1;
          state     <= S_HOLD;
        end else if (fast_sat) begin
          pend_gray <= '0;
          pend_zero <= 1'b0;
          state     <= S_HOLD;
        end else begin
          state <= S_DIV;
        end
      end else if (take) begin
        state <= S_IDLE;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pin_checker.sv
`default_nettype none
module pin_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [pin_pkg::PIX_W-1:0] gray_out,
  input wire logic                      zero_max
);
  import pin_pkg::*;

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(gray_out) && $stable(zero_max))
    else $error("stalled result word changed");

  // A zero maximum always forces full scale.
  a_zero_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_max |-> gray_out == PIX_W'(FULL_SCALE))
    else $error("zero maximum without full-scale gray");

  // Reset leaves no result word behind.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

  // The handshake outputs are always known once out of reset.
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({in_stall, out_valid}))
    else $error("handshake output unknown");

endmodule

bind posterize_invert_normalize_unit pin_checker u_pin_checker (.*);
`default_nettype wire
